@@ rtl/png_pkg.sv @@
// shared constants, types and layout functions for the pyramid neighborhood gather
`default_nettype none

package png_pkg;

	// item kinds carried in tuser
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ROWS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_COLS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_SIZE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT   = 2'd3;

	// register reset values
	localparam logic [8:0] RST_BASE_ROWS     = 9'd256;
	localparam logic [8:0] RST_BASE_COLS     = 9'd256;
	localparam logic [2:0] RST_NEIGHBOR_SIZE = 3'd5;
	localparam logic [2:0] RST_LEVEL_COUNT   = 3'd4;

	// parameter defaults
	localparam int DEF_MAX_ROWS     = 256;
	localparam int DEF_MAX_COLS     = 256;
	localparam int DEF_MAX_LEVELS   = 4;
	localparam int DEF_MAX_NEIGHBOR = 7;

	// results per query are capped here
	localparam int MAX_RESULTS = 45;

	// stream payload widths
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 24;

	typedef logic [23:0] pixel_t;

	// first address of a level: each level is sized for the largest dimensions
	function automatic int level_offset(input int lvl, input int max_rows, input int max_cols);
		int off;
		int r;
		int c;
		off = 0;
		r = max_rows;
		c = max_cols;
		for (int k = 0; k < lvl; k++) begin
			off = off + r * c;
			r = (r + 1) >> 1;
			c = (c + 1) >> 1;
		end
		return off;
	endfunction

	// row pitch of a level
	function automatic int level_stride(input int lvl, input int max_cols);
		return (max_cols + (1 << lvl) - 1) >> lvl;
	endfunction

endpackage

`default_nettype wire

@@ rtl/pyramid_neighborhood_gather_top.sv @@
// pyramid neighborhood gather: pixel pyramid store and causal neighborhood streamer
// sequence: a write transfer is registered in the address stage and then stored in the pixel memory;
//   a query first runs the 8-step position remainder, then the corner, then issues reads that pass
//   the address stage and the pixel memory read into the output queue
// throughput: writes 1 per cycle while no query holds the input; a query blocks the input until its
//   last read is issued, one pixel memory read giving one result per cycle when the output never stalls
// reset: control, pipeline valids and configuration registers return to defaults; pixel memory is not cleared
`default_nettype none

module pyramid_neighborhood_gather_top #(
	parameter int MAX_ROWS     = png_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS     = png_pkg::DEF_MAX_COLS,
	parameter int MAX_LEVELS   = png_pkg::DEF_MAX_LEVELS,
	parameter int MAX_NEIGHBOR = png_pkg::DEF_MAX_NEIGHBOR
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [png_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [png_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input items
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// tdata: level[1:0], row[9:2], col[17:10], red[25:18], green[33:26], blue[41:34], zeros
	input  wire logic [png_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// tuser: op
	input  wire logic                              s_axis_tuser,
	// result items
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// tdata: out_red[7:0], out_green[15:8], out_blue[23:16]
	output logic [png_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
	output logic                                   m_axis_tlast
);
	import png_pkg::*;

	// widths derived from the size limits
	localparam int RCW = $clog2(MAX_ROWS + 1);          // row count
	localparam int CCW = $clog2(MAX_COLS + 1);          // column count
	localparam int RIW = $clog2(MAX_ROWS);              // row index
	localparam int CIW = $clog2(MAX_COLS);              // column index
	localparam int LVW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int LCW = $clog2(MAX_LEVELS + 1);
	localparam int STORE_DEPTH = level_offset(MAX_LEVELS, MAX_ROWS, MAX_COLS);
	localparam int AW  = $clog2(STORE_DEPTH);
	localparam int CW  = $clog2(MAX_RESULTS);
	localparam int FIFO_DEPTH = 4;
	localparam int FPW = 2;
	localparam int OCW = 3;

	// sequencer states
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_MOD    = 2'd1;
	localparam logic [1:0] ST_CORNER = 2'd2;
	localparam logic [1:0] ST_GATHER = 2'd3;

	// window phases
	localparam logic [1:0] PH_ABOVE  = 2'd0;
	localparam logic [1:0] PH_LEFT   = 2'd1;
	localparam logic [1:0] PH_COARSE = 2'd2;

	// configuration registers
	logic [8:0] base_rows_q;
	logic [8:0] base_cols_q;
	logic [2:0] neighbor_size_q;
	logic [2:0] level_count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_rows_q     <= RST_BASE_ROWS;
			base_cols_q     <= RST_BASE_COLS;
			neighbor_size_q <= RST_NEIGHBOR_SIZE;
			level_count_q   <= RST_LEVEL_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BASE_ROWS:     base_rows_q     <= cfg_data;
				REG_BASE_COLS:     base_cols_q     <= cfg_data;
				REG_NEIGHBOR_SIZE: neighbor_size_q <= cfg_data[2:0];
				REG_LEVEL_COUNT:   level_count_q   <= cfg_data[2:0];
			endcase
		end
	end

	// clamped working values
	logic [RCW-1:0] rows0;
	logic [CCW-1:0] cols0;
	logic [2:0]     nb;
	logic [1:0]     half;
	logic [LCW-1:0] levels;

	always_comb begin
		if (base_rows_q == 9'd0)
			rows0 = RCW'(1);
		else if (32'(base_rows_q) > MAX_ROWS)
			rows0 = RCW'(MAX_ROWS);
		else
			rows0 = RCW'(base_rows_q);
		if (base_cols_q == 9'd0)
			cols0 = CCW'(1);
		else if (32'(base_cols_q) > MAX_COLS)
			cols0 = CCW'(MAX_COLS);
		else
			cols0 = CCW'(base_cols_q);
		if (neighbor_size_q < 3'd2)
			nb = 3'd2;
		else if (32'(neighbor_size_q) > MAX_NEIGHBOR)
			nb = 3'(MAX_NEIGHBOR);
		else
			nb = neighbor_size_q;
		if (level_count_q == 3'd0)
			levels = LCW'(1);
		else if (32'(level_count_q) > MAX_LEVELS)
			levels = LCW'(MAX_LEVELS);
		else
			levels = LCW'(level_count_q);
	end

	assign half = nb[2:1];

	// level dimensions: repeated round-up halving equals one rounded-up shift
	function automatic logic [RCW-1:0] row_dim(input logic [LVW-1:0] lv);
		logic [RCW+7:0] t;
		t = (RCW+8)'(rows0) + ((RCW+8)'(1) << lv) - (RCW+8)'(1);
		return RCW'(t >> lv);
	endfunction

	function automatic logic [CCW-1:0] col_dim(input logic [LVW-1:0] lv);
		logic [CCW+7:0] t;
		t = (CCW+8)'(cols0) + ((CCW+8)'(1) << lv) - (CCW+8)'(1);
		return CCW'(t >> lv);
	endfunction

	// wrapping position increments
	function automatic logic [RIW-1:0] row_inc(input logic [RIW-1:0] v, input logic [RCW-1:0] n);
		logic [RCW-1:0] t;
		t = RCW'(v) + RCW'(1);
		return (t == n) ? RIW'(0) : RIW'(t);
	endfunction

	function automatic logic [CIW-1:0] col_inc(input logic [CIW-1:0] v, input logic [CCW-1:0] n);
		logic [CCW-1:0] t;
		t = CCW'(v) + CCW'(1);
		return (t == n) ? CIW'(0) : CIW'(t);
	endfunction

	// input payload
	logic [1:0] in_level;
	logic [7:0] in_row;
	logic [7:0] in_col;
	pixel_t     in_pixel;

	assign in_level = s_axis_tdata[1:0];
	assign in_row   = s_axis_tdata[9:2];
	assign in_col   = s_axis_tdata[17:10];
	assign in_pixel = s_axis_tdata[41:18];

	logic [1:0] state_q;
	logic       in_acc;
	logic       lv_ok;
	logic [RCW-1:0] in_rows;
	logic [CCW-1:0] in_cols;
	logic       write_ok;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign lv_ok    = 32'(in_level) < 32'(levels);
	assign in_rows  = row_dim(LVW'(in_level));
	assign in_cols  = col_dim(LVW'(in_level));
	assign write_ok = in_acc && (s_axis_tuser == OP_WRITE) && lv_ok
		&& (32'(in_row) < 32'(in_rows)) && (32'(in_col) < 32'(in_cols));

	// sequencer registers
	logic [1:0]     phase_q;
	logic [2:0]     bit_q;
	logic [7:0]     row_sh_q;
	logic [7:0]     col_sh_q;
	logic [RCW-1:0] rem_r_q;
	logic [CCW-1:0] rem_c_q;
	logic [RCW-1:0] rows_q;
	logic [CCW-1:0] cols_q;
	logic [LVW-1:0] cur_lv_q;
	logic [RIW-1:0] rp_q;
	logic [CIW-1:0] cp_q;
	logic [RIW-1:0] base_r_q;
	logic [CIW-1:0] base_c_q;
	logic [2:0]     i_q;
	logic [2:0]     j_q;
	logic [2:0]     m_q;
	logic [CW-1:0]  count_q;
	logic [OCW-1:0] outstanding_q;

	// remainder step, one dividend bit a cycle
	logic [RCW:0] rt;
	logic [CCW:0] ct;
	always_comb begin
		rt = {rem_r_q, row_sh_q[7]};
		if (rt >= (RCW+1)'(rows_q))
			rt = rt - (RCW+1)'(rows_q);
		ct = {rem_c_q, col_sh_q[7]};
		if (ct >= (CCW+1)'(cols_q))
			ct = ct - (CCW+1)'(cols_q);
	end

	// window corner: (pos + count - half mod count) mod count
	logic [RCW:0] hr;
	logic [CCW:0] hc;
	logic [RCW:0] r0;
	logic [CCW:0] c0;
	always_comb begin
		hr = (RCW+1)'(half);
		hc = (CCW+1)'(half);
		for (int k = 0; k < 3; k++) begin
			if (hr >= (RCW+1)'(rows_q))
				hr = hr - (RCW+1)'(rows_q);
			if (hc >= (CCW+1)'(cols_q))
				hc = hc - (CCW+1)'(cols_q);
		end
		r0 = (RCW+1)'(rem_r_q) + (RCW+1)'(rows_q) - hr;
		if (r0 >= (RCW+1)'(rows_q))
			r0 = r0 - (RCW+1)'(rows_q);
		c0 = (CCW+1)'(rem_c_q) + (CCW+1)'(cols_q) - hc;
		if (c0 >= (CCW+1)'(cols_q))
			c0 = c0 - (CCW+1)'(cols_q);
	end

	// window walk
	logic [2:0]     win_w;
	logic [2:0]     win_h;
	logic           end_row;
	logic           end_win;
	logic           last_win;
	logic           trunc;
	logic           issue;
	logic           emit_last;
	logic [LVW-1:0] next_lv;
	logic [3:0]     m_sum;
	logic [RIW-1:0] rp_inc;
	logic [CIW-1:0] cp_inc;

	always_comb begin
		unique case (phase_q)
			PH_ABOVE: begin
				win_w = nb;
				win_h = {1'b0, half};
			end
			PH_LEFT: begin
				win_w = {1'b0, half};
				win_h = 3'd1;
			end
			default: begin
				win_w = m_q;
				win_h = m_q;
			end
		endcase
	end

	assign end_row   = (j_q == win_w - 3'd1);
	assign end_win   = end_row && (i_q == win_h - 3'd1);
	assign last_win  = (phase_q != PH_ABOVE) && (32'(cur_lv_q) + 1 == 32'(levels));
	assign trunc     = (32'(count_q) == MAX_RESULTS - 1);
	assign issue     = (state_q == ST_GATHER) && (32'(outstanding_q) < FIFO_DEPTH);
	assign emit_last = (end_win && last_win) || trunc;
	assign next_lv   = cur_lv_q + LVW'(1);
	assign m_sum     = {1'b0, m_q} + 4'd1;
	assign rp_inc    = row_inc(rp_q, rows_q);
	assign cp_inc    = col_inc(cp_q, cols_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_axis_tuser == OP_QUERY) && lv_ok)
						state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (bit_q == 3'd7)
						state_q <= ST_CORNER;
				end
				ST_CORNER: state_q <= ST_GATHER;
				ST_GATHER: begin
					if (issue && emit_last)
						state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				row_sh_q <= in_row;
				col_sh_q <= in_col;
				rem_r_q  <= '0;
				rem_c_q  <= '0;
				bit_q    <= 3'd0;
				rows_q   <= in_rows;
				cols_q   <= in_cols;
				cur_lv_q <= LVW'(in_level);
			end
			ST_MOD: begin
				rem_r_q  <= RCW'(rt);
				rem_c_q  <= CCW'(ct);
				row_sh_q <= {row_sh_q[6:0], 1'b0};
				col_sh_q <= {col_sh_q[6:0], 1'b0};
				bit_q    <= bit_q + 3'd1;
			end
			ST_CORNER: begin
				base_r_q <= RIW'(r0);
				base_c_q <= CIW'(c0);
				rp_q     <= RIW'(r0);
				cp_q     <= CIW'(c0);
				i_q      <= 3'd0;
				j_q      <= 3'd0;
				m_q      <= nb;
				phase_q  <= PH_ABOVE;
				count_q  <= '0;
			end
			ST_GATHER: begin
				if (issue) begin
					count_q <= count_q + CW'(1);
					if (!end_row) begin
						j_q  <= j_q + 3'd1;
						cp_q <= cp_inc;
					end else if (!end_win) begin
						j_q  <= 3'd0;
						i_q  <= i_q + 3'd1;
						cp_q <= base_c_q;
						rp_q <= rp_inc;
					end else if (phase_q == PH_ABOVE) begin
						// left run sits on the row just below the above block
						phase_q <= PH_LEFT;
						i_q     <= 3'd0;
						j_q     <= 3'd0;
						cp_q    <= base_c_q;
						rp_q    <= rp_inc;
					end else begin
						// next coarser level: corner halves, window shrinks
						phase_q  <= PH_COARSE;
						cur_lv_q <= next_lv;
						rows_q   <= row_dim(next_lv);
						cols_q   <= col_dim(next_lv);
						base_r_q <= base_r_q >> 1;
						base_c_q <= base_c_q >> 1;
						rp_q     <= base_r_q >> 1;
						cp_q     <= base_c_q >> 1;
						m_q      <= m_sum[3:1];
						i_q      <= 3'd0;
						j_q      <= 3'd0;
					end
				end
			end
		endcase
	end

	// address stage: row times pitch, plus level offset and column
	logic [LVW-1:0] sel_lv;
	logic [RIW-1:0] sel_r;
	logic [CIW-1:0] sel_c;
	logic [AW-1:0]  sel_off;
	logic [AW-1:0]  sel_stride;

	assign sel_lv = issue ? cur_lv_q : LVW'(in_level);
	assign sel_r  = issue ? rp_q : RIW'(in_row);
	assign sel_c  = issue ? cp_q : CIW'(in_col);

	always_comb begin
		sel_off    = '0;
		sel_stride = '0;
		for (int k = 0; k < MAX_LEVELS; k++) begin
			if (sel_lv == LVW'(k)) begin
				sel_off    = AW'(level_offset(k, MAX_ROWS, MAX_COLS));
				sel_stride = AW'(level_stride(k, MAX_COLS));
			end
		end
	end

	logic          rd_s1;
	logic          wr_s1;
	logic          last_s1;
	logic [AW-1:0] prod_s1;
	logic [AW-1:0] base_s1;
	pixel_t        wdata_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			wr_s1 <= 1'b0;
		end else begin
			rd_s1 <= issue;
			wr_s1 <= write_ok;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= AW'(sel_r) * sel_stride;
		base_s1  <= sel_off + AW'(sel_c);
		last_s1  <= emit_last;
		wdata_s1 <= in_pixel;
	end

	// pixel memory, one read and one write port
	pixel_t        pixel_store [STORE_DEPTH];
	logic [AW-1:0] mem_addr;
	pixel_t        rdata_s2;
	logic          rd_s2;
	logic          last_s2;

	assign mem_addr = prod_s1 + base_s1;

	always_ff @(posedge clk) begin
		if (wr_s1)
			pixel_store[mem_addr] <= wdata_s1;
		if (rd_s1)
			rdata_s2 <= pixel_store[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s2   <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			rd_s2   <= rd_s1;
			last_s2 <= last_s1;
		end
	end

	// output queue; reads are issued only against free entries
	logic [24:0]    fifo_q [FIFO_DEPTH];
	logic [FPW-1:0] wr_ptr_q;
	logic [FPW-1:0] rd_ptr_q;
	logic [OCW-1:0] fifo_cnt_q;
	logic           pop;

	assign m_axis_tvalid = (fifo_cnt_q != '0);
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = fifo_q[rd_ptr_q][23:0];
	assign m_axis_tlast  = fifo_q[rd_ptr_q][24];

	always_ff @(posedge clk) begin
		if (rd_s2)
			fifo_q[wr_ptr_q] <= {last_s2, rdata_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
			fifo_cnt_q    <= '0;
			outstanding_q <= '0;
		end else begin
			if (rd_s2)
				wr_ptr_q <= wr_ptr_q + FPW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FPW'(1);
			fifo_cnt_q    <= fifo_cnt_q + OCW'(rd_s2) - OCW'(pop);
			outstanding_q <= outstanding_q + OCW'(issue) - OCW'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	// queued results never exceed issued reads
	a_fifo_credit: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= outstanding_q)
		else $error("output queue holds more than was issued");

	// reads in flight never exceed the queue entries
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(outstanding_q) <= FIFO_DEPTH)
		else $error("more reads outstanding than queue entries");

	// walk position stays inside the current level
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GATHER) |-> ((32'(rp_q) < 32'(rows_q)) && (32'(cp_q) < 32'(cols_q))))
		else $error("gather position outside level");

	// a store never shares the address stage with a gather read
	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_s1 && wr_s1))
		else $error("read and write in one address slot");
`endif

endmodule

`default_nettype wire
